/* rtl/bcf_pkg.sv */
// ============================================================================
// bcf_pkg
// Shared types, constants and helpers of the Bezier curve flattener: item
// formats, datapath operation codes, and controller/datapath command buses.
// ============================================================================
package bcf_pkg;

    // Coordinate width (signed Q15.8) and default weight fraction width
    localparam int COORD_BITS      = 24;
    localparam int T_FRAC_BITS_DEF = 16;

    // Steps-per-curve register
    localparam int              STEPS_W     = 6;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 6'd16;

    // One curve item
    typedef struct packed {
        logic                         func;
        logic signed [COORD_BITS-1:0] p0_x;
        logic signed [COORD_BITS-1:0] p0_y;
        logic signed [COORD_BITS-1:0] p1_x;
        logic signed [COORD_BITS-1:0] p1_y;
        logic signed [COORD_BITS-1:0] p2_x;
        logic signed [COORD_BITS-1:0] p2_y;
        logic signed [COORD_BITS-1:0] p3_x;
        logic signed [COORD_BITS-1:0] p3_y;
    } curve_t;

    // One output point item
    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last_point;
    } result_t;

    // Multiplier operations, in cubic issue order
    typedef enum logic [3:0] {
        OP_UU, OP_TU, OP_TT,
        OP_W0, OP_W1, OP_W2, OP_W3,
        OP_X0, OP_X1, OP_X2, OP_X3,
        OP_Y0, OP_Y1, OP_Y2, OP_Y3
    } bcf_op_t;

    localparam logic [3:0] OPS_LAST_CUBIC = 4'd14;
    localparam logic [3:0] OPS_LAST_QUAD  = 4'd10;

    // Operation at slot idx of a point; quadratic skips the cubic weight ops
    function automatic bcf_op_t op_at(input logic cubic, input logic [3:0] idx);
        logic [3:0] code;
        if (cubic || (idx < 4'd3)) begin
            code = idx;
        end else begin
            code = idx + 4'd4;
        end
        return bcf_op_t'(code);
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic               load;
        logic               div_step;
        logic               div_first;
        logic               t_init;
        logic               t_step;
        logic               op_valid;
        bcf_op_t            op;
        logic               finish;
        logic               emit_end;
        logic [STEPS_W-1:0] steps;
    } bcf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cubic;
    } bcf_sts_t;

endpackage

/* rtl/bcf_dp.sv */
// ============================================================================
// bcf_dp
// Datapath: reciprocal step divider for t = k/steps, exact t stepping, one
// shared multiplier with a registered product, weight and accumulate
// write-back, and the rounding/saturating result register.
// ============================================================================
module bcf_dp #(
    parameter int T_FRAC_BITS = bcf_pkg::T_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bcf_pkg::curve_t   curve,
    input  bcf_pkg::bcf_cmd_t cmd,
    output bcf_pkg::bcf_sts_t sts,
    output bcf_pkg::result_t  result,
    output logic              result_strobe
);
    import bcf_pkg::*;

    localparam int T    = T_FRAC_BITS;
    localparam int SW   = STEPS_W;
    localparam int CW   = COORD_BITS;
    localparam int AW   = ((CW > T + 3) ? CW : T + 3) + 1;
    localparam int BW   = T + 2;
    localparam int PW   = AW + BW;
    localparam int ACCW = CW + T + 4;

    localparam logic [T:0]                 ONE_T    = {1'b1, {T{1'b0}}};
    localparam logic signed [PW-1:0]       HALF_P   = PW'(ONE_T >> 1);
    localparam logic signed [ACCW-1:0]     HALF_A   = ACCW'(ONE_T >> 1);
    localparam logic signed [ACCW-1:0]     C_MAX    = ACCW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [ACCW-1:0]     C_MIN    = -C_MAX - ACCW'(1);

    // Captured item
    logic                 cubic_reg;
    logic signed [CW-1:0] px_reg [4];
    logic signed [CW-1:0] py_reg [4];

    // Divider and t stepping
    logic [SW-1:0] rem_reg;
    logic [T:0]    q_reg;
    logic [T:0]    t_reg;
    logic [SW+1:0] tr_reg;

    // Weights
    logic [T:0] uu_reg, tu_reg, tt_reg;
    logic [T:0] w_reg [4];

    // Multiplier stage and accumulators
    logic signed [PW-1:0]   prod_reg;
    bcf_op_t                tag_reg;
    logic                   tag_vld_reg;
    logic signed [ACCW-1:0] accx_reg, accy_reg;

    // Output register
    result_t res_reg;
    logic    res_vld_reg;

    logic [T:0]    u;
    logic [SW:0]   shifted;
    logic          div_ge;
    logic [SW+1:0] tr_sum;
    logic [SW+1:0] mod2;
    logic          wrap;
    logic [T+2:0]  tu3, tt3;
    logic signed [AW-1:0] a_op;
    logic [T:0]           b_op;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] wsum;
    logic [T:0]           w_round;
    logic signed [ACCW-1:0] prod_ext;

    assign sts.cubic     = cubic_reg;
    assign result        = res_reg;
    assign result_strobe = res_vld_reg;

    // Rounded and saturated point coordinate
    function automatic logic signed [CW-1:0] finish_coord(input logic signed [ACCW-1:0] acc);
        logic signed [ACCW-1:0] s;
        logic signed [ACCW-1:0] q;
        s = acc + HALF_A;
        q = s >>> T;
        if (q > C_MAX) begin
            q = C_MAX;
        end else if (q < C_MIN) begin
            q = C_MIN;
        end
        return q[CW-1:0];
    endfunction

    // Complement of t
    assign u = ONE_T - t_reg;

    // Restoring divide of 2^T by steps, one quotient bit per cycle
    assign shifted = {rem_reg, cmd.div_first};
    assign div_ge  = shifted >= {1'b0, cmd.steps};

    // Exact t = round(k / steps): add quotient, carry from remainder mod 2*steps
    assign tr_sum = tr_reg + {1'b0, rem_reg, 1'b0};
    assign mod2   = {1'b0, cmd.steps, 1'b0};
    assign wrap   = tr_sum >= mod2;

    // Three times tu and tt
    assign tu3 = {1'b0, tu_reg, 1'b0} + {2'b0, tu_reg};
    assign tt3 = {1'b0, tt_reg, 1'b0} + {2'b0, tt_reg};

    // Operand select for the shared multiplier
    always_comb
    begin
        a_op = '0;
        b_op = '0;
        case (cmd.op)
            OP_UU: begin a_op = $signed({{(AW-T-1){1'b0}}, u});      b_op = u;     end
            OP_TU: begin a_op = $signed({{(AW-T-1){1'b0}}, t_reg});  b_op = u;     end
            OP_TT: begin a_op = $signed({{(AW-T-1){1'b0}}, t_reg});  b_op = t_reg; end
            OP_W0: begin a_op = $signed({{(AW-T-1){1'b0}}, uu_reg}); b_op = u;     end
            OP_W1: begin a_op = $signed({{(AW-T-3){1'b0}}, tu3});    b_op = u;     end
            OP_W2: begin a_op = $signed({{(AW-T-3){1'b0}}, tt3});    b_op = u;     end
            OP_W3: begin a_op = $signed({{(AW-T-1){1'b0}}, tt_reg}); b_op = t_reg; end
            OP_X0: begin a_op = AW'(px_reg[0]); b_op = w_reg[0]; end
            OP_X1: begin a_op = AW'(px_reg[1]); b_op = w_reg[1]; end
            OP_X2: begin a_op = AW'(px_reg[2]); b_op = w_reg[2]; end
            OP_X3: begin a_op = AW'(px_reg[3]); b_op = w_reg[3]; end
            OP_Y0: begin a_op = AW'(py_reg[0]); b_op = w_reg[0]; end
            OP_Y1: begin a_op = AW'(py_reg[1]); b_op = w_reg[1]; end
            OP_Y2: begin a_op = AW'(py_reg[2]); b_op = w_reg[2]; end
            OP_Y3: begin a_op = AW'(py_reg[3]); b_op = w_reg[3]; end
            default: begin a_op = '0; b_op = '0; end
        endcase
    end

    assign prod = a_op * $signed({1'b0, b_op});

    // Write-back: rounded weight or signed accumulate term
    assign wsum     = prod_reg + HALF_P;
    assign w_round  = wsum[2*T:T];
    assign prod_ext = ACCW'(prod_reg);

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tag_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            tag_vld_reg <= cmd.op_valid;
            res_vld_reg <= cmd.finish | cmd.emit_end;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        // item capture
        if (cmd.load) begin
            cubic_reg <= curve.func;
            px_reg[0] <= curve.p0_x;
            py_reg[0] <= curve.p0_y;
            px_reg[1] <= curve.p1_x;
            py_reg[1] <= curve.p1_y;
            px_reg[2] <= curve.p2_x;
            py_reg[2] <= curve.p2_y;
            px_reg[3] <= curve.p3_x;
            py_reg[3] <= curve.p3_y;
            rem_reg   <= '0;
            q_reg     <= '0;
        end

        // divider step
        if (cmd.div_step) begin
            rem_reg <= div_ge ? SW'(shifted - {1'b0, cmd.steps}) : shifted[SW-1:0];
            q_reg   <= {q_reg[T-1:0], div_ge};
        end

        // t sequence
        if (cmd.t_init) begin
            t_reg  <= '0;
            tr_reg <= {2'b00, cmd.steps};
        end else if (cmd.t_step) begin
            t_reg  <= t_reg + q_reg + (T+1)'(wrap);
            tr_reg <= wrap ? (tr_sum - mod2) : tr_sum;
        end

        // multiplier stage
        if (cmd.op_valid) begin
            prod_reg <= prod;
            tag_reg  <= cmd.op;
        end

        // write-back
        if (cmd.op_valid && (cmd.op == OP_UU)) begin
            accx_reg <= '0;
            accy_reg <= '0;
        end else if (tag_vld_reg) begin
            case (tag_reg)
                OP_UU: begin
                    uu_reg <= w_round;
                    if (!cubic_reg) begin
                        w_reg[0] <= w_round;
                    end
                end
                OP_TU: begin
                    tu_reg <= w_round;
                    if (!cubic_reg) begin
                        w_reg[1] <= {w_round[T-1:0], 1'b0};
                    end
                end
                OP_TT: begin
                    tt_reg <= w_round;
                    if (!cubic_reg) begin
                        w_reg[2] <= w_round;
                        w_reg[3] <= '0;
                    end
                end
                OP_W0: w_reg[0] <= w_round;
                OP_W1: w_reg[1] <= w_round;
                OP_W2: w_reg[2] <= w_round;
                OP_W3: w_reg[3] <= w_round;
                OP_X0, OP_X1, OP_X2, OP_X3: accx_reg <= accx_reg + prod_ext;
                OP_Y0, OP_Y1, OP_Y2, OP_Y3: accy_reg <= accy_reg + prod_ext;
                default: ;
            endcase
        end

        // output point
        if (cmd.finish) begin
            res_reg.point_x    <= finish_coord(accx_reg);
            res_reg.point_y    <= finish_coord(accy_reg);
            res_reg.last_point <= 1'b0;
        end else if (cmd.emit_end) begin
            res_reg.point_x    <= cubic_reg ? px_reg[3] : px_reg[2];
            res_reg.point_y    <= cubic_reg ? py_reg[3] : py_reg[2];
            res_reg.last_point <= 1'b1;
        end
    end

endmodule

/* rtl/bcf_ctrl.sv */
// ============================================================================
// bcf_ctrl
// Controller: holds the steps register, sequences the divider, the per-point
// multiplier operations and the point/endpoint emission.
// ============================================================================
module bcf_ctrl #(
    parameter int T_FRAC_BITS = bcf_pkg::T_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bcf_pkg::STEPS_W-1:0]  cfg_data,
    input  bcf_pkg::bcf_sts_t            sts,
    output bcf_pkg::bcf_cmd_t            cmd
);
    import bcf_pkg::*;

    localparam int DCW = $clog2(T_FRAC_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_OPS, S_DRAIN, S_FINISH, S_ENDPT
    } state_t;

    state_t             state_reg, state_next;
    logic [STEPS_W-1:0] steps_reg, steps_next;
    logic [STEPS_W-1:0] s_eff_reg, s_eff_next;
    logic [STEPS_W-1:0] k_reg, k_next;
    logic [DCW-1:0]     cnt_reg, cnt_next;
    logic [3:0]         opi_reg, opi_next;
    logic [3:0]         op_last;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign op_last   = sts.cubic ? OPS_LAST_CUBIC : OPS_LAST_QUAD;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        steps_next = steps_reg;
        s_eff_next = s_eff_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        opi_next   = opi_reg;

        cmd           = '0;
        cmd.op        = op_at(sts.cubic, opi_reg);
        cmd.steps     = s_eff_reg;
        cmd.div_first = (cnt_reg == '0);

        if (cfg_valid) begin
            steps_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cmd.load   = 1'b1;
                    s_eff_next = (steps_reg == '0) ? STEPS_W'(1) : steps_reg;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DCW'(1);
                if (cnt_reg == DCW'(T_FRAC_BITS)) begin
                    cmd.t_init = 1'b1;
                    k_next     = '0;
                    opi_next   = '0;
                    state_next = S_OPS;
                end
            end
            S_OPS: begin
                cmd.op_valid = 1'b1;
                opi_next     = opi_reg + 4'd1;
                if (opi_reg == op_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                cmd.t_step = 1'b1;
                opi_next   = '0;
                k_next     = k_reg + STEPS_W'(1);
                if (k_reg == s_eff_reg - STEPS_W'(1)) begin
                    state_next = S_ENDPT;
                end else begin
                    state_next = S_OPS;
                end
            end
            S_ENDPT: begin
                cmd.emit_end = 1'b1;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            steps_reg <= STEPS_RESET;
            s_eff_reg <= STEPS_W'(1);
            k_reg     <= '0;
            cnt_reg   <= '0;
            opi_reg   <= '0;
        end else begin
            state_reg <= state_next;
            steps_reg <= steps_next;
            s_eff_reg <= s_eff_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            opi_reg   <= opi_next;
        end
    end

endmodule

/* rtl/bezier_curve_flattener_core.sv */
// ============================================================================
// bezier_curve_flattener_core
// Flattens one quadratic or cubic Bezier curve per item into steps + 1
// points: Bernstein evaluation at t = k/steps, then the final control point.
// ============================================================================
// A curve is taken when start is high and busy is low; busy then stays high
// until the last point has been issued. Each point appears on result for one
// cycle with result_strobe high and cannot be held off, so the receiver must
// take every strobed point. Per curve the block first runs the bit-serial
// reciprocal divide of 2^T by steps, then the multiplier operations of each
// point, fewer for a quadratic than for a cubic (all products go through one
// shared multiplier), then emits the endpoint. The steps register may
// be written while busy is low; a value of zero acts as one.
module bezier_curve_flattener_core #(
    parameter int T_FRAC_BITS = bcf_pkg::T_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bcf_pkg::curve_t             curve,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bcf_pkg::STEPS_W-1:0] cfg_data,
    output bcf_pkg::result_t            result,
    output logic                        result_strobe
);
    import bcf_pkg::*;

    bcf_cmd_t cmd;
    bcf_sts_t sts;

    // Sequencer
    bcf_ctrl #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic
    bcf_dp #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .curve         (curve),
        .cmd           (cmd),
        .sts           (sts),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

/* test/tb_bezier_curve_flattener_core.sv */
// ============================================================================
// tb_bezier_curve_flattener_core
// Self-checking bench for the curve flattener: drives quadratic and cubic
// curves in random bursts, predicts every emitted point in fixed point and
// compares each strobed point against the oldest prediction.
// ============================================================================
module tb_bezier_curve_flattener_core;

    import bcf_pkg::*;

    localparam int     T_FRAC      = T_FRAC_BITS_DEF;
    localparam longint T_ONE       = longint'(1) << T_FRAC;
    localparam longint T_HALF      = longint'(1) << (T_FRAC - 1);
    localparam longint COORD_HI    = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_LO    = -(longint'(1) << (COORD_BITS - 1));
    localparam int     STALL_LIMIT = 5000;
    localparam int     TAIL_CYCLES = 40;
    localparam int     N_PHASES    = 6;
    localparam int     PHASE_ITEMS = 26;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                start         = 1'b0;
    logic                busy;
    curve_t              curve         = '0;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [STEPS_W-1:0]  cfg_data      = '0;
    result_t             result;
    logic                result_strobe;

    // Bench state
    curve_t              curve_queue[$];
    result_t             predicted_points[$];
    logic [STEPS_W-1:0]  steps_cfg     = STEPS_RESET;
    int                  mismatches    = 0;
    int                  idle_cycles   = 0;
    int                  gap_max       = 0;
    int                  burst_left    = 0;
    int                  gap_left      = 0;

    bezier_curve_flattener_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .curve         (curve),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result        (result),
        .result_strobe (result_strobe)
    );

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Round half up on a non-negative Q0.T product
    function automatic longint rnd_t(input longint x);
        return (x + T_HALF) >> T_FRAC;
    endfunction

    // Round half up the weighted sum back to Q15.8 and clamp
    function automatic logic signed [COORD_BITS-1:0] round_sat(input longint acc);
        longint r;
        r = (acc + T_HALF) >>> T_FRAC;
        if (r < COORD_LO)
        begin
            r = COORD_LO;
        end
        else if (r > COORD_HI)
        begin
            r = COORD_HI;
        end
        return r[COORD_BITS-1:0];
    endfunction

    // Append one expected point
    task automatic expect_point(input result_t pt);
        predicted_points.insert(predicted_points.size(), pt);
    endtask

    // Append one pending curve item for the driver
    task automatic queue_curve(input curve_t c);
        curve_queue.insert(curve_queue.size(), c);
    endtask

    // Expected points of one curve under the current steps setting
    task automatic flatten_curve(input curve_t c);
        longint  nsteps;
        longint  t;
        longint  u;
        longint  uu;
        longint  tu;
        longint  tt;
        longint  ax;
        longint  ay;
        longint  w[4];
        longint  px[4];
        longint  py[4];
        result_t pt;
        int      k;
        int      i;
        nsteps = (steps_cfg == 0) ? 1 : longint'(steps_cfg);
        px[0] = c.p0_x;  py[0] = c.p0_y;
        px[1] = c.p1_x;  py[1] = c.p1_y;
        px[2] = c.p2_x;  py[2] = c.p2_y;
        px[3] = c.p3_x;  py[3] = c.p3_y;
        for (k = 0; k < nsteps; k++)
        begin
            t  = ((longint'(k) << (T_FRAC + 1)) + nsteps) / (2 * nsteps);
            u  = T_ONE - t;
            uu = rnd_t(u * u);
            tu = rnd_t(t * u);
            tt = rnd_t(t * t);
            if (c.func)
            begin
                w[0] = rnd_t(uu * u);
                w[1] = rnd_t(3 * tu * u);
                w[2] = rnd_t(3 * tt * u);
                w[3] = rnd_t(tt * t);
            end
            else
            begin
                w[0] = uu;
                w[1] = 2 * tu;
                w[2] = tt;
                w[3] = 0;
            end
            ax = 0;
            ay = 0;
            for (i = 0; i < 4; i++)
            begin
                ax += px[i] * w[i];
                ay += py[i] * w[i];
            end
            pt.point_x    = round_sat(ax);
            pt.point_y    = round_sat(ay);
            pt.last_point = 1'b0;
            expect_point(pt);
        end
        // endpoint is the last control point, untouched
        pt.point_x    = c.func ? c.p3_x : c.p2_x;
        pt.point_y    = c.func ? c.p3_y : c.p2_y;
        pt.last_point = 1'b1;
        expect_point(pt);
    endtask

    task automatic compare_field(input string field,
                                 input logic signed [COORD_BITS-1:0] want,
                                 input logic signed [COORD_BITS-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    // Coordinate mix: extremes, small values around zero, full range
    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        logic signed [COORD_BITS-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = COORD_HI[COORD_BITS-1:0];
            1:       v = COORD_LO[COORD_BITS-1:0];
            2:       v = COORD_BITS'($urandom_range(0, 2000) - 1000);
            default: v = COORD_BITS'($urandom());
        endcase
        return v;
    endfunction

    function automatic curve_t random_curve(input logic func);
        curve_t c;
        c.func = func;
        c.p0_x = rand_coord();  c.p0_y = rand_coord();
        c.p1_x = rand_coord();  c.p1_y = rand_coord();
        c.p2_x = rand_coord();  c.p2_y = rand_coord();
        c.p3_x = rand_coord();  c.p3_y = rand_coord();
        return c;
    endfunction

    function automatic curve_t uniform_curve(input logic func, input longint v);
        curve_t c;
        c.func = func;
        c.p0_x = v[COORD_BITS-1:0];  c.p0_y = v[COORD_BITS-1:0];
        c.p1_x = v[COORD_BITS-1:0];  c.p1_y = v[COORD_BITS-1:0];
        c.p2_x = v[COORD_BITS-1:0];  c.p2_y = v[COORD_BITS-1:0];
        c.p3_x = v[COORD_BITS-1:0];  c.p3_y = v[COORD_BITS-1:0];
        return c;
    endfunction

    // Control points swing between the two extremes
    function automatic curve_t alternating_curve(input logic func);
        curve_t c;
        c = uniform_curve(func, COORD_HI);
        c.p1_x = COORD_LO[COORD_BITS-1:0];
        c.p3_x = COORD_LO[COORD_BITS-1:0];
        c.p0_y = COORD_LO[COORD_BITS-1:0];
        c.p2_y = COORD_LO[COORD_BITS-1:0];
        return c;
    endfunction

    // Steps register write; only called with nothing in flight
    task automatic write_steps(input logic [STEPS_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Sampled on the falling edge, clear of the driver and monitor updates
    task automatic wait_drained();
        do
            @(negedge clk);
        while (curve_queue.size() != 0 || start || predicted_points.size() != 0);
    endtask

    // Curve driver: bursts of items separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            curve      <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                void'(curve_queue.pop_front());
                if (burst_left > 0)
                begin
                    burst_left--;
                end
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, gap_max);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (curve_queue.size() != 0)
            begin
                start <= 1'b1;
                curve <= curve_queue[0];
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: config tracking, prediction on accept, point checks, watchdog
    always @(posedge clk)
    begin
        result_t want;
        logic    progress;
        if (rst_n)
        begin
            progress = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                steps_cfg = cfg_data;
                progress  = 1'b1;
            end
            if (start && !busy)
            begin
                flatten_curve(curve);
                progress = 1'b1;
            end
            if (result_strobe)
            begin
                progress = 1'b1;
                if (predicted_points.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected point, expected none, actual x=%0d y=%0d last=%0b",
                             $time, result.point_x, result.point_y, result.last_point);
                end
                else
                begin
                    want = predicted_points.pop_front();
                    compare_field("point_x", want.point_x, result.point_x);
                    compare_field("point_y", want.point_y, result.point_y);
                    compare_field("last_point", want.last_point, result.last_point);
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
                $display("** bezier_curve_flattener_core: FAILED **");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int                 p;
        int                 n;
        logic [STEPS_W-1:0] steps_val;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, steps at reset value
        gap_max = 3;
        queue_curve(uniform_curve(1'b0, 0));
        queue_curve(uniform_curve(1'b1, COORD_HI));
        queue_curve(uniform_curve(1'b0, COORD_LO));
        queue_curve(alternating_curve(1'b1));
        queue_curve(alternating_curve(1'b0));
        queue_curve(random_curve(1'b1));
        queue_curve(random_curve(1'b0));
        wait_drained();

        // zero steps acts as one
        write_steps('0);
        queue_curve(random_curve(1'b0));
        queue_curve(random_curve(1'b1));
        queue_curve(uniform_curve(1'b1, COORD_LO));
        wait_drained();

        // largest step count
        write_steps('1);
        queue_curve(alternating_curve(1'b1));
        queue_curve(uniform_curve(1'b0, COORD_HI));
        queue_curve(random_curve(1'b1));
        wait_drained();

        write_steps(STEPS_W'(1));
        queue_curve(random_curve(1'b0));
        queue_curve(uniform_curve(1'b1, COORD_HI));
        wait_drained();

        // random phases, mostly small step counts
        for (p = 0; p < N_PHASES; p++)
        begin
            case ($urandom_range(0, 5))
                0:       steps_val = '0;
                1:       steps_val = '1;
                2:       steps_val = STEPS_W'(1);
                default: steps_val = STEPS_W'($urandom_range(2, 12));
            endcase
            write_steps(steps_val);
            gap_max = (p % 3 == 0) ? 0 : 20;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                queue_curve(random_curve(1'($urandom_range(0, 1))));
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("** bezier_curve_flattener_core: PASSED **");
        end
        else
        begin
            $display("** bezier_curve_flattener_core: FAILED **");
        end
        $finish;
    end

endmodule

/* bezier_curve_flattener_core.f */
rtl/bcf_pkg.sv
rtl/bcf_dp.sv
rtl/bcf_ctrl.sv
rtl/bezier_curve_flattener_core.sv
test/tb_bezier_curve_flattener_core.sv
